// ----- rtl/sdpt_pkg.sv -----
package sdpt_pkg;

	localparam int unsigned DebounceWidth = 8;
	localparam int unsigned HeldWidth     = 16;
	localparam int unsigned LevelWidth    = 3;
	localparam int unsigned CfgIndexWidth = 3;
	localparam int unsigned CfgDataWidth  = 16;
	localparam int unsigned NumLevels     = 4;

	localparam logic [CfgIndexWidth-1:0] CFG_DEBOUNCE_TICKS    = 3'd0;
	localparam logic [CfgIndexWidth-1:0] CFG_LEVEL_ONE_TICKS   = 3'd1;
	localparam logic [CfgIndexWidth-1:0] CFG_LEVEL_TWO_TICKS   = 3'd2;
	localparam logic [CfgIndexWidth-1:0] CFG_LEVEL_THREE_TICKS = 3'd3;
	localparam logic [CfgIndexWidth-1:0] CFG_LEVEL_FOUR_TICKS  = 3'd4;

	localparam logic [DebounceWidth-1:0] DEBOUNCE_RESET    = 8'd10;
	localparam logic [HeldWidth-1:0]     LEVEL_ONE_RESET   = 16'd400;
	localparam logic [HeldWidth-1:0]     LEVEL_TWO_RESET   = 16'd800;
	localparam logic [HeldWidth-1:0]     LEVEL_THREE_RESET = 16'd1200;
	localparam logic [HeldWidth-1:0]     LEVEL_FOUR_RESET  = 16'd1600;

	localparam logic [1:0] PHASE_CODE_RELEASED   = 2'd0;
	localparam logic [1:0] PHASE_CODE_TO_RELEASE = 2'd1;
	localparam logic [1:0] PHASE_CODE_HELD       = 2'd2;
	localparam logic [1:0] PHASE_CODE_TO_HOLD    = 2'd3;

	typedef enum logic [3:0] {
		PH_RELEASED   = 4'b0001,
		PH_TO_RELEASE = 4'b0010,
		PH_HELD       = 4'b0100,
		PH_TO_HOLD    = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [DebounceWidth-1:0]                debounce_ticks;
		logic [NumLevels-1:0][HeldWidth-1:0]     level_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]            phase;
		logic [HeldWidth-1:0]  held_ticks;
		logic [LevelWidth-1:0] press_level;
		logic                  hold_started;
		logic                  hold_ended;
		logic [LevelWidth-1:0] final_level;
	} result_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_RELEASED:   code = PHASE_CODE_RELEASED;
			PH_TO_RELEASE: code = PHASE_CODE_TO_RELEASE;
			PH_HELD:       code = PHASE_CODE_HELD;
			PH_TO_HOLD:    code = PHASE_CODE_TO_HOLD;
			default:       code = PHASE_CODE_RELEASED;
		endcase
		return code;
	endfunction

	function automatic logic [LevelWidth-1:0] level_of(
		input logic [HeldWidth-1:0] t,
		input cfg_t                 cfg
	);
		logic [LevelWidth-1:0] n;
		n = '0;
		for (int i = 0; i < NumLevels; i++) begin
			if (t >= cfg.level_ticks[i]) begin
				n = n + LevelWidth'(1);
			end
		end
		return n;
	endfunction

endpackage

// ----- rtl/sdpt_cfg.sv -----
module sdpt_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sdpt_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  logic [sdpt_pkg::CfgDataWidth-1:0]    cfg_data,
	output sdpt_pkg::cfg_t                       cfg
);

	sdpt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= sdpt_pkg::DEBOUNCE_RESET;
			cfg_q.level_ticks[0] <= sdpt_pkg::LEVEL_ONE_RESET;
			cfg_q.level_ticks[1] <= sdpt_pkg::LEVEL_TWO_RESET;
			cfg_q.level_ticks[2] <= sdpt_pkg::LEVEL_THREE_RESET;
			cfg_q.level_ticks[3] <= sdpt_pkg::LEVEL_FOUR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				sdpt_pkg::CFG_DEBOUNCE_TICKS:
					cfg_q.debounce_ticks <= cfg_data[sdpt_pkg::DebounceWidth-1:0];
				sdpt_pkg::CFG_LEVEL_ONE_TICKS:   cfg_q.level_ticks[0] <= cfg_data;
				sdpt_pkg::CFG_LEVEL_TWO_TICKS:   cfg_q.level_ticks[1] <= cfg_data;
				sdpt_pkg::CFG_LEVEL_THREE_TICKS: cfg_q.level_ticks[2] <= cfg_data;
				sdpt_pkg::CFG_LEVEL_FOUR_TICKS:  cfg_q.level_ticks[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/sdpt_core.sv -----
module sdpt_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              raw_hold,
	input  sdpt_pkg::cfg_t    cfg,
	output sdpt_pkg::result_t result
);

	sdpt_pkg::phase_t                      phase_q, phase_d;
	logic [sdpt_pkg::DebounceWidth-1:0]    debounce_q, debounce_d;
	logic [sdpt_pkg::HeldWidth-1:0]        held_q, held_d;
	logic                                  started, ended;
	logic [sdpt_pkg::LevelWidth-1:0]       final_lv;

	always_comb begin
		phase_d    = phase_q;
		debounce_d = debounce_q;
		held_d     = held_q;
		started    = 1'b0;
		ended      = 1'b0;
		final_lv   = '0;
		if (debounce_q != '0) begin
			debounce_d = debounce_q - sdpt_pkg::DebounceWidth'(1);
		end else if (!raw_hold) begin
			case (phase_q)
				sdpt_pkg::PH_HELD: begin
					phase_d    = sdpt_pkg::PH_TO_RELEASE;
					debounce_d = cfg.debounce_ticks;
					ended      = 1'b1;
					final_lv   = sdpt_pkg::level_of(held_q, cfg);
				end
				sdpt_pkg::PH_TO_RELEASE: phase_d = sdpt_pkg::PH_RELEASED;
				default: ;
			endcase
		end else begin
			case (phase_q)
				sdpt_pkg::PH_RELEASED: begin
					phase_d    = sdpt_pkg::PH_TO_HOLD;
					debounce_d = cfg.debounce_ticks;
				end
				sdpt_pkg::PH_TO_HOLD: begin
					phase_d = sdpt_pkg::PH_HELD;
					held_d  = '0;
					started = 1'b1;
				end
				default: begin
					if (held_q != '1) begin
						held_d = held_q + sdpt_pkg::HeldWidth'(1);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= sdpt_pkg::PH_RELEASED;
			debounce_q <= '0;
			held_q     <= '0;
		end else if (advance) begin
			phase_q    <= phase_d;
			debounce_q <= debounce_d;
			held_q     <= held_d;
		end
	end

	always_comb begin
		result.phase        = sdpt_pkg::phase_code(phase_d);
		result.held_ticks   = held_d;
		result.press_level  = sdpt_pkg::level_of(held_d, cfg);
		result.hold_started = started;
		result.hold_ended   = ended;
		result.final_level  = final_lv;
	end

endmodule

// ----- rtl/switch_debounce_press_timer.sv -----
// Switch debouncer with press timing. Feed one word per 1 ms tick carrying raw_hold;
// every accepted word yields exactly one result word, registered in the next cycle, and
// a new word is taken every clock while the output side keeps up (one tick per cycle,
// set by the single result register). A level change starts a debounce countdown of
// debounce_ticks ticks during which ticks only count down. Once a hold is confirmed,
// held_ticks counts hold ticks (saturating) and press_level reports how many of the
// four level thresholds it has reached. hold_started pulses on confirmation;
// hold_ended pulses when the held phase is left, with final_level carrying the level
// reached. Write thresholds only while no word is in flight.
module switch_debounce_press_timer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sdpt_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  logic [sdpt_pkg::CfgDataWidth-1:0]    cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 raw_hold,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           phase,
	output logic [sdpt_pkg::HeldWidth-1:0]       held_ticks,
	output logic [sdpt_pkg::LevelWidth-1:0]      press_level,
	output logic                                 hold_started,
	output logic                                 hold_ended,
	output logic [sdpt_pkg::LevelWidth-1:0]      final_level
);

	sdpt_pkg::cfg_t    cfg;
	sdpt_pkg::result_t result;
	sdpt_pkg::result_t result_q;
	logic              out_valid_q;
	logic              in_accept;

	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	sdpt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sdpt_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (in_accept),
		.raw_hold (raw_hold),
		.cfg      (cfg),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			result_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign phase        = result_q.phase;
	assign held_ticks   = result_q.held_ticks;
	assign press_level  = result_q.press_level;
	assign hold_started = result_q.hold_started;
	assign hold_ended   = result_q.hold_ended;
	assign final_level  = result_q.final_level;

	a_pulses_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hold_started && hold_ended))
		else $error("hold start and end in one word");

	a_start_in_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hold_started) |->
			(phase == sdpt_pkg::PHASE_CODE_HELD && held_ticks == '0))
		else $error("hold start without held phase and cleared count");

	a_end_to_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hold_ended) |-> (phase == sdpt_pkg::PHASE_CODE_TO_RELEASE))
		else $error("hold end without release debounce");

	a_final_only_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hold_ended) |-> (final_level == '0))
		else $error("final level outside hold end");

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(held_ticks)))
		else $error("stalled result word lost");

endmodule
